// File: hw/rtl/drc_pkg.sv
package drc_pkg;

    localparam int DEPTH_BITS_DEFAULT    = 16;
    localparam int FRACTION_BITS_DEFAULT = 16;
    localparam int DEPTH_PORT_BITS       = 16;
    localparam int QUEUE_DEPTH           = 4;

    typedef logic [1:0] op_t;

    localparam op_t OP_START   = 2'd0;
    localparam op_t OP_MEASURE = 2'd1;
    localparam op_t OP_COLOR   = 2'd2;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_BLANK  = 2'd0;
    localparam kind_t KIND_LOW    = 2'd1;
    localparam kind_t KIND_HIGH   = 2'd2;
    localparam kind_t KIND_DIVIDE = 2'd3;

endpackage

// File: hw/rtl/depth_range_to_colormap_core.sv
// Colors a depth frame with a jet ramp scaled to the frame's own depth range. Stream each
// frame twice: a start transaction (operation 0) clears the range, measure transactions
// (operation 1) track the smallest and largest nonzero depth, and color transactions
// (operation 2) each return one RGBA pixel; code 3 is dropped. Start and measure
// transactions are taken one per clock while the queue is not full. A color transaction
// is classified on entry and waits in a 4-entry queue for the back end, which loads it,
// runs its restoring divider at one fraction bit per cycle when the depth lies strictly
// inside the range, then forms the color into the output register once that register is
// free or being popped, and only then takes the next one. Invalid, flat or clamped pixels
// skip the divider. full rises once the queue holds 4 color transactions. The depth range is
// sampled when the color transaction enters, so measure and color passes may overlap.
module depth_range_to_colormap_core #(
    parameter int DEPTH_BITS    = drc_pkg::DEPTH_BITS_DEFAULT,
    parameter int FRACTION_BITS = drc_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          operation,
    input  logic [drc_pkg::DEPTH_PORT_BITS-1:0] depth,
    output logic                                empty,
    input  logic                                pop,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue,
    output logic [7:0]                          alpha
);

    localparam int ITEM_BITS = 2 * DEPTH_BITS + 2;

    logic                 accept;
    logic                 item_push;
    logic [ITEM_BITS-1:0] item_data;
    logic [ITEM_BITS-1:0] queue_data;
    logic                 queue_empty;
    logic                 item_pop;

    assign accept = push && !full;

    drc_front #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .depth     (depth),
        .item_push (item_push),
        .item_data (item_data)
    );

    drc_queue #(
        .WIDTH (ITEM_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_push),
        .push_data (item_data),
        .pop       (item_pop),
        .pop_data  (queue_data),
        .full      (full),
        .empty     (queue_empty)
    );

    drc_back #(
        .DEPTH_BITS    (DEPTH_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ready (!queue_empty),
        .item_data  (queue_data),
        .item_pop   (item_pop),
        .pop        (pop),
        .empty      (empty),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha)
    );

endmodule

// File: hw/rtl/drc_front.sv
module drc_front #(
    parameter int DEPTH_BITS = drc_pkg::DEPTH_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  drc_pkg::op_t                           operation,
    input  logic [drc_pkg::DEPTH_PORT_BITS-1:0]    depth,
    output logic                                   item_push,
    output logic [2*DEPTH_BITS+1:0]                item_data
);

    logic [DEPTH_BITS-1:0] d;
    logic [DEPTH_BITS-1:0] range_low_reg;
    logic [DEPTH_BITS-1:0] range_low_next;
    logic [DEPTH_BITS-1:0] range_high_reg;
    logic [DEPTH_BITS-1:0] range_high_next;
    drc_pkg::kind_t        kind;

    genvar i;
    generate
        for (i = 0; i < DEPTH_BITS; i++)
        begin : g_depth
            if (i < drc_pkg::DEPTH_PORT_BITS)
            begin : g_bit
                assign d[i] = depth[i];
            end
            else
            begin : g_zero
                assign d[i] = 1'b0;
            end
        end
    endgenerate

    // range tracking over nonzero depths
    always_comb
    begin
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        if (accept)
        begin
            case (operation)
                drc_pkg::OP_START:
                begin
                    range_low_next  = '1;
                    range_high_next = '0;
                end
                drc_pkg::OP_MEASURE:
                begin
                    if (d != '0)
                    begin
                        if (d < range_low_reg)
                        begin
                            range_low_next = d;
                        end
                        if (d > range_high_reg)
                        begin
                            range_high_next = d;
                        end
                    end
                end
                default:
                begin
                    range_low_next  = range_low_reg;
                    range_high_next = range_high_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '1;
            range_high_reg <= '0;
        end
        else
        begin
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
        end
    end

    // classify color transactions
    always_comb
    begin
        if (d == '0 || range_high_reg <= range_low_reg)
        begin
            kind = drc_pkg::KIND_BLANK;
        end
        else if (d <= range_low_reg)
        begin
            kind = drc_pkg::KIND_LOW;
        end
        else if (d >= range_high_reg)
        begin
            kind = drc_pkg::KIND_HIGH;
        end
        else
        begin
            kind = drc_pkg::KIND_DIVIDE;
        end
    end

    assign item_push = accept && (operation == drc_pkg::OP_COLOR);
    assign item_data = {kind, d - range_low_reg, range_high_reg - range_low_reg};

endmodule

// File: hw/rtl/drc_queue.sv
module drc_queue #(
    parameter int WIDTH = 34
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_BITS = $clog2(drc_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(drc_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [drc_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CNT_BITS'(drc_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(drc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(drc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];

endmodule

// File: hw/rtl/drc_back.sv
module drc_back #(
    parameter int DEPTH_BITS    = drc_pkg::DEPTH_BITS_DEFAULT,
    parameter int FRACTION_BITS = drc_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_ready,
    input  logic [2*DEPTH_BITS+1:0]   item_data,
    output logic                      item_pop,
    input  logic                      pop,
    output logic                      empty,
    output logic [7:0]                red,
    output logic [7:0]                green,
    output logic [7:0]                blue,
    output logic [7:0]                alpha
);

    localparam int F        = FRACTION_BITS;
    localparam int XW       = F + 3;
    localparam int CW       = $clog2(F + 1);
    localparam int UNIT_INT = 1 << F;
    localparam logic signed [XW-1:0] Q1     = XW'(UNIT_INT / 4);
    localparam logic signed [XW-1:0] Q3     = XW'((UNIT_INT * 3) / 4);
    localparam logic signed [XW-1:0] NEG_Q1 = XW'(-(UNIT_INT / 4));
    localparam logic signed [XW-1:0] NEG_Q3 = XW'(-((UNIT_INT * 3) / 4));
    localparam logic signed [XW-1:0] HALF   = XW'(UNIT_INT / 2);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIVIDE = 2'd1;
    localparam logic [1:0] ST_COLOR  = 2'd2;

    function automatic logic [7:0] channel_of(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] tmp;
        logic [F:0]           t;
        logic [F+8:0]         p;
        tmp = '0;
        t   = '0;
        p   = '0;
        if (x <= NEG_Q3)
        begin
            return 8'd0;
        end
        else if (x <= NEG_Q1)
        begin
            tmp = (x + Q3) <<< 1;
        end
        else if (x <= Q1)
        begin
            return 8'hFF;
        end
        else if (x <= Q3)
        begin
            tmp = (Q3 - x) <<< 1;
        end
        else
        begin
            return 8'd0;
        end
        t = tmp[F:0];
        p = {t, 8'd0} - {8'd0, t};
        return p[F+7:F];
    endfunction

    drc_pkg::kind_t        kind;
    logic [DEPTH_BITS-1:0] num;
    logic [DEPTH_BITS-1:0] den;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [F:0]            v_reg;
    logic [F:0]            v_next;
    logic [DEPTH_BITS-1:0] rem_reg;
    logic [DEPTH_BITS-1:0] rem_next;
    logic [DEPTH_BITS-1:0] den_reg;
    logic [DEPTH_BITS-1:0] den_next;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic                  blank_reg;
    logic                  blank_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [7:0]            red_reg;
    logic [7:0]            green_reg;
    logic [7:0]            blue_reg;
    logic [7:0]            alpha_reg;
    logic                  out_load;
    logic [DEPTH_BITS:0]   shifted;
    logic                  take;
    logic signed [XW-1:0]  xv;

    assign {kind, num, den} = item_data;

    assign shifted  = {rem_reg, 1'b0};
    assign take     = (shifted >= {1'b0, den_reg});
    assign item_pop = (state_reg == ST_IDLE) && item_ready;
    assign out_load = (state_reg == ST_COLOR) && (!out_valid_reg || pop);
    assign xv       = signed'({2'b00, v_reg});

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        blank_next = blank_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_ready)
                begin
                    blank_next = (kind == drc_pkg::KIND_BLANK);
                    rem_next   = num;
                    den_next   = den;
                    cnt_next   = CW'(F);
                    v_next     = '0;
                    state_next = ST_COLOR;
                    case (kind)
                        drc_pkg::KIND_HIGH:
                        begin
                            v_next = {1'b1, {F{1'b0}}};
                        end
                        drc_pkg::KIND_DIVIDE:
                        begin
                            state_next = ST_DIVIDE;
                        end
                        default:
                        begin
                            v_next = '0;
                        end
                    endcase
                end
            end
            ST_DIVIDE:
            begin
                // restoring division, one quotient bit a cycle
                rem_next = take ? DEPTH_BITS'(shifted - {1'b0, den_reg})
                                : shifted[DEPTH_BITS-1:0];
                v_next   = {v_reg[F-1:0], take};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_COLOR;
                end
            end
            ST_COLOR:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        cnt_reg   <= cnt_next;
        blank_reg <= blank_next;
        if (out_load)
        begin
            if (blank_reg)
            begin
                red_reg   <= 8'd0;
                green_reg <= 8'd0;
                blue_reg  <= 8'd0;
                alpha_reg <= 8'd0;
            end
            else
            begin
                red_reg   <= channel_of(xv - HALF);
                green_reg <= channel_of(xv);
                blue_reg  <= channel_of(xv + HALF);
                alpha_reg <= 8'hFF;
            end
        end
    end

    assign empty = !out_valid_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;
    assign alpha = alpha_reg;

endmodule

// File: hw/rtl/drc_checker.sv
module drc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic [7:0] alpha
);

    // queue sides come out of reset drained
    assert property (@(posedge clk) $rose(rst_n) |-> (empty && !full))
        else $error("not drained after reset");

    // a waiting transaction holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(red) && $stable(green)
                              && $stable(blue) && $stable(alpha)))
        else $error("result changed while waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (alpha == 8'd0 || alpha == 8'hFF))
        else $error("alpha neither clear nor opaque");

    // invalid pixel is all zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && alpha == 8'd0) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
        else $error("transparent pixel has color");

endmodule

bind depth_range_to_colormap_core drc_checker u_drc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .red   (red),
    .green (green),
    .blue  (blue),
    .alpha (alpha)
);
